// ===== src/astar_pkg.sv =====
// ----------------------------------------------------------------------------
// astar_pkg
// shared types and constants for the a* search block
// ----------------------------------------------------------------------------
`default_nettype none

package astar_pkg;

    localparam int MAX_NODES   = 32;
    localparam int MAX_EDGES   = 128;
    localparam int COST_BITS   = 16;
    localparam int MAX_RESULTS = 32;
    localparam int NODE_W      = 5;
    localparam int EDGE_W      = 7;
    localparam int ETOT_W      = 8;
    localparam int F_W         = 21;
    localparam int CNT_W       = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam logic [F_W-1:0] F_MAX = {F_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_HEUR  = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_RUN   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_GOAL  = 2'd1,
        CFG_COUNT = 2'd2
    } cfg_idx_t;

    // one classified command as it travels from front to back
    typedef struct packed {
        req_t                 kind;
        logic [NODE_W-1:0]    node_a;
        logic [NODE_W-1:0]    node_b;
        logic [COST_BITS-1:0] cost;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_EMIT,
        ST_EDGE_RD,
        ST_EDGE,
        ST_DONE
    } state_t;

    function automatic logic [F_W-1:0] sat_add(input logic [F_W-1:0] a,
                                               input logic [F_W-1:0] b);
        logic [F_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[F_W] ? F_MAX : s[F_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/a_star_shortest_path_search.sv =====
// ----------------------------------------------------------------------------
// a_star_shortest_path_search
// a* search engine over a small undirected weighted graph
// ----------------------------------------------------------------------------
// usage
//   a command beat is taken when start is high and busy is low; req_type
//   selects heuristic load, edge append, search run or edge clear
//   load beats are taken one per cycle while the 4-deep queue has room and no run is queued or running
//   a run beat makes busy stay high until its search has left its done state
//   each closed node comes out for one cycle with done high; the receiver
//   cannot stall, and the final beat of a run carries last (and
//   reached_goal if the goal was closed)
//   configuration (start, goal, node count) is written through cfg_we,
//   cfg_index, cfg_data; the user writes it only while the block is idle, which the block itself does not enforce
// operation (node count capped at 32)
//   a run is popped after it is taken, then goes through the init state
//   each expansion scans the nodes one a cycle through the heuristic ram
//   port, then passes the emit state, and when the search goes on reads and
//   relaxes every stored edge in turn; a beat is held until the next
//   expansion emits and then shows through a register, the final beat
//   in the cycle after busy falls
// reset
//   clears the queue, the edge count and the open/closed sets; heuristics
//   and edges are undefined until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module a_star_shortest_path_search (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   req_type,
    input  wire logic [astar_pkg::NODE_W-1:0] node_a,
    input  wire logic [astar_pkg::NODE_W-1:0] node_b,
    input  wire logic [15:0]                  weight,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [5:0]                   cfg_data,
    output logic                              done,
    output logic [astar_pkg::NODE_W-1:0]      node_id,
    output logic [astar_pkg::F_W-1:0]         f_value,
    output logic                              last,
    output logic                              reached_goal
);
    import astar_pkg::*;

    logic [NODE_W-1:0] start_reg, goal_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              q_valid, q_pop, back_busy;
    cmd_t              q_cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            goal_reg  <= '0;
            count_reg <= CNT_W'(MAX_NODES);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START: start_reg <= cfg_data[NODE_W-1:0];
                CFG_GOAL:  goal_reg  <= cfg_data[NODE_W-1:0];
                CFG_COUNT: count_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    astar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .node_a    (node_a),
        .node_b    (node_b),
        .weight    (weight),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .back_busy (back_busy)
    );

    astar_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .back_busy    (back_busy),
        .home_node    (start_reg),
        .dest_node    (goal_reg),
        .node_count   (count_reg),
        .done         (done),
        .node_id      (node_id),
        .f_value      (f_value),
        .last         (last),
        .reached_goal (reached_goal)
    );

endmodule

`default_nettype wire

// ===== src/astar_ram.sv =====
// ----------------------------------------------------------------------------
// astar_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module astar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/astar_front.sv =====
// ----------------------------------------------------------------------------
// astar_front
// accepts commands, classifies them and queues them for the search engine
// ----------------------------------------------------------------------------
`default_nettype none

module astar_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [1:0]                    req_type,
    input  wire logic [astar_pkg::NODE_W-1:0]  node_a,
    input  wire logic [astar_pkg::NODE_W-1:0]  node_b,
    input  wire logic [15:0]                   weight,
    output logic                               busy,
    output logic                               q_valid,
    output astar_pkg::cmd_t                    q_cmd,
    input  wire logic                          q_pop,
    input  wire logic                          back_busy
);
    import astar_pkg::*;

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              run_pend_reg, run_pend_next;
    logic              push;
    cmd_t              in_cmd;

    // a full queue or a queued or running search holds off new commands
    assign busy = (fill_reg == QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH))
                  || run_pend_reg || back_busy;
    assign push = start && !busy;

    always_comb
    begin
        in_cmd.kind   = req_t'(req_type);
        in_cmd.node_a = node_a;
        in_cmd.node_b = node_b;
        in_cmd.cost   = weight[COST_BITS-1:0];
    end

    assign q_valid = (fill_reg != '0);
    assign q_cmd   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next   = rd_ptr_reg + QPTR_W'(q_pop);
        fill_next     = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
        run_pend_next = run_pend_reg;
        if (push && in_cmd.kind == REQ_RUN)
        begin
            run_pend_next = 1'b1;
        end
        else if (q_pop && q_cmd.kind == REQ_RUN)
        begin
            run_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            run_pend_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            run_pend_reg <= run_pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/astar_back.sv =====
// ----------------------------------------------------------------------------
// astar_back
// executes loads and clears and runs the search: scan open set, emit, relax edges
// ----------------------------------------------------------------------------
`default_nettype none

module astar_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire astar_pkg::cmd_t              q_cmd,
    output logic                              q_pop,
    output logic                              back_busy,
    input  wire logic [astar_pkg::NODE_W-1:0] home_node,
    input  wire logic [astar_pkg::NODE_W-1:0] dest_node,
    input  wire logic [astar_pkg::CNT_W-1:0]  node_count,
    output logic                              done,
    output logic [astar_pkg::NODE_W-1:0]      node_id,
    output logic [astar_pkg::F_W-1:0]         f_value,
    output logic                              last,
    output logic                              reached_goal
);
    import astar_pkg::*;

    state_t state_reg, state_next;

    logic [MAX_NODES-1:0]  open_reg, open_next;
    logic [MAX_NODES-1:0]  closed_reg, closed_next;
    logic [F_W-1:0]        g_reg [MAX_NODES];
    logic [ETOT_W-1:0]     etot_reg, etot_next;
    logic [CNT_W-1:0]      n_reg;
    logic [NODE_W-1:0]     scan_reg;
    logic                  any_reg;
    logic [NODE_W-1:0]     best_reg;
    logic [F_W-1:0]        bestf_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [EDGE_W-1:0]     eidx_reg;
    logic [F_W-1:0]        bestg_reg;

    logic                  heur_we;
    logic [COST_BITS-1:0]  heur_rd;
    logic                  edge_we;
    logic [2*NODE_W+COST_BITS-1:0] edge_rd;
    logic [NODE_W-1:0]     scan_rd_addr;
    logic [EDGE_W-1:0]     edge_rd_addr;

    logic                  pend_valid_reg;
    logic [NODE_W-1:0]     pend_node_reg;
    logic                  scan_last;
    logic [F_W-1:0]        cand_f;
    logic                  out_valid_reg;
    logic [NODE_W-1:0]     out_node_reg;
    logic [F_W-1:0]        out_f_reg;
    logic                  out_last_reg;
    logic                  out_goal_reg;
    logic                  is_run;

    // the back pops the front end's queue as soon as it is idle
    assign is_run = q_cmd.kind == REQ_RUN;
    assign heur_we = q_pop && q_cmd.kind == REQ_HEUR;
    assign edge_we = q_pop && q_cmd.kind == REQ_EDGE && etot_reg < ETOT_W'(MAX_EDGES);

    assign scan_rd_addr = scan_reg;
    assign edge_rd_addr = eidx_reg;

    astar_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_NODES)) u_heur (
        .clk   (clk),
        .we    (heur_we),
        .waddr (q_cmd.node_a),
        .wdata (q_cmd.cost),
        .raddr (scan_rd_addr),
        .rdata (heur_rd)
    );

    astar_ram #(.WIDTH(2*NODE_W+COST_BITS), .DEPTH(MAX_EDGES)) u_edge (
        .clk   (clk),
        .we    (edge_we),
        .waddr (etot_reg[EDGE_W-1:0]),
        .wdata ({q_cmd.cost, q_cmd.node_b, q_cmd.node_a}),
        .raddr (edge_rd_addr),
        .rdata (edge_rd)
    );

    // pend_node_reg is the node whose heuristic sits on heur_rd
    assign cand_f    = sat_add(g_reg[pend_node_reg], {{(F_W-COST_BITS){1'b0}}, heur_rd});
    assign scan_last = ({1'b0, scan_reg} + CNT_W'(1) >= n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && is_run)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ({1'b0, home_node} < n_reg) ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (pend_valid_reg && pend_node_reg == NODE_W'(n_reg - CNT_W'(1)))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!any_reg || best_reg == dest_node
                    || cnt_reg + CNT_W'(1) >= CNT_W'(MAX_RESULTS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = (etot_reg == '0) ? ST_SCAN : ST_EDGE_RD;
                end
            end
            ST_EDGE_RD:
            begin
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                state_next = ({1'b0, eidx_reg} + ETOT_W'(1) >= etot_reg) ? ST_SCAN
                                                                          : ST_EDGE_RD;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        q_pop     = (state_reg == ST_IDLE) && q_valid;
        back_busy = (state_reg != ST_IDLE);
    end

    always_comb
    begin
        etot_next = etot_reg;
        if (q_pop && q_cmd.kind == REQ_CLEAR)
        begin
            etot_next = '0;
        end
        else if (edge_we)
        begin
            etot_next = etot_reg + ETOT_W'(1);
        end
    end

    // open / closed bookkeeping
    logic [NODE_W-1:0] ea, eb, nb;
    logic [F_W-1:0]    cand_g;
    logic              e_hit;
    always_comb
    begin
        ea     = edge_rd[NODE_W-1:0];
        eb     = edge_rd[2*NODE_W-1:NODE_W];
        nb     = (ea == best_reg) ? eb : ea;
        cand_g = sat_add(bestg_reg, {{(F_W-COST_BITS){1'b0}},
                                     edge_rd[2*NODE_W+COST_BITS-1:2*NODE_W]});
        e_hit  = ({1'b0, ea} < n_reg) && ({1'b0, eb} < n_reg) && (ea != eb)
                 && (ea == best_reg || eb == best_reg) && !closed_reg[nb]
                 && (!open_reg[nb] || cand_g < g_reg[nb]);
        open_next   = open_reg;
        closed_next = closed_reg;
        case (state_reg)
            ST_INIT:
            begin
                open_next   = '0;
                closed_next = '0;
                open_next[home_node] = 1'b1;
            end
            ST_EMIT:
            begin
                if (any_reg)
                begin
                    open_next[best_reg]   = 1'b0;
                    closed_next[best_reg] = 1'b1;
                end
            end
            ST_EDGE:
            begin
                if (e_hit)
                begin
                    open_next[nb] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INIT)
        begin
            g_reg[home_node] <= '0;
        end
        else if (state_reg == ST_EDGE && e_hit)
        begin
            g_reg[nb] <= cand_g;
        end
        if (state_reg == ST_EMIT)
        begin
            bestg_reg <= g_reg[best_reg];
        end
        out_node_reg <= best_reg;
        out_f_reg    <= bestf_reg;
        out_goal_reg <= (best_reg == dest_node);
        out_last_reg <= (best_reg == dest_node)
                        || (cnt_reg + CNT_W'(1) >= CNT_W'(MAX_RESULTS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            open_reg       <= '0;
            closed_reg     <= '0;
            etot_reg       <= '0;
            n_reg          <= '0;
            scan_reg       <= '0;
            any_reg        <= 1'b0;
            best_reg       <= '0;
            bestf_reg      <= '0;
            cnt_reg        <= '0;
            eidx_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_node_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            open_reg   <= open_next;
            closed_reg <= closed_next;
            etot_reg   <= etot_next;
            out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    n_reg   <= (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                                 : node_count;
                    cnt_reg <= '0;
                end
                ST_INIT:
                begin
                    scan_reg       <= '0;
                    any_reg        <= 1'b0;
                    pend_valid_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    // read heuristic of scan_reg, compare it in the cycle after
                    pend_valid_reg <= 1'b1;
                    pend_node_reg  <= scan_reg;
                    if (!scan_last)
                    begin
                        scan_reg <= scan_reg + NODE_W'(1);
                    end
                    if (pend_valid_reg && open_reg[pend_node_reg]
                        && (!any_reg || cand_f < bestf_reg))
                    begin
                        any_reg   <= 1'b1;
                        best_reg  <= pend_node_reg;
                        bestf_reg <= cand_f;
                    end
                end
                ST_EMIT:
                begin
                    eidx_reg       <= '0;
                    scan_reg       <= '0;
                    pend_valid_reg <= 1'b0;
                    any_reg        <= 1'b0;
                    if (any_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        cnt_reg       <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_EDGE:
                begin
                    eidx_reg <= eidx_reg + EDGE_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // results are held one beat so an open-set-empty end can flag the previous one
    logic hold_valid_reg;
    logic [NODE_W-1:0] hold_node_reg;
    logic [F_W-1:0]    hold_f_reg;
    logic              hold_last_reg, hold_goal_reg;
    logic              flush;
    logic              flush_reg;

    // the run closes in the cycle after the done state, once its last beat is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_reg <= 1'b0;
        end
        else
        begin
            flush_reg <= (state_reg == ST_DONE);
        end
    end

    assign flush = flush_reg;

    always_ff @(posedge clk)
    begin
        if (out_valid_reg)
        begin
            hold_node_reg <= out_node_reg;
            hold_f_reg    <= out_f_reg;
            hold_last_reg <= out_last_reg;
            hold_goal_reg <= out_goal_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (out_valid_reg)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (flush)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // a held beat goes out when the next one arrives or the run closes
    logic emit_now;
    assign emit_now = hold_valid_reg && (out_valid_reg || flush);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= emit_now;
        end
    end

    always_ff @(posedge clk)
    begin
        node_id      <= hold_node_reg;
        f_value      <= hold_f_reg;
        last         <= flush ? 1'b1 : hold_last_reg;
        reached_goal <= flush ? hold_goal_reg && hold_last_reg : 1'b0;
    end

endmodule

`default_nettype wire

// ===== bench/a_star_shortest_path_search_test.sv =====
// ----------------------------------------------------------------------------
// a_star_shortest_path_search_test
// self-checking bench for the a* search block: a table of directed commands,
// then random phases of heuristic loads, edge appends, clears and search
// runs under several configurations. every closed-node beat is compared
// against a typed table row or a software search over its own copy of the graph
// ----------------------------------------------------------------------------
`default_nettype none

module a_star_shortest_path_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    import astar_pkg::*;

    localparam int RANDOM_ITEMS = 370;
    localparam int STALL_LIMIT  = 5000;   // cycles with no beat in either direction
    localparam int DRAIN_CYCLES = 64;     // load beats may still sit in the queue
    localparam int NO_REPORT    = 10;

    // one result beat
    typedef struct {
        logic [NODE_W-1:0] node;
        logic [F_W-1:0]    f;
        logic              last;
        logic              goal;
    } closed_beat_t;

    // one row of the directed table: either a register write or a command
    typedef struct {
        bit                   is_cfg;
        cfg_idx_t             idx;
        logic [5:0]           data;
        req_t                 req;
        logic [NODE_W-1:0]    a;
        logic [NODE_W-1:0]    b;
        logic [15:0]          w;
        bit                   typed;    // expectation written out in the row
        int                   tn;       // 0 or 1 typed beats
        logic [NODE_W-1:0]    tnode;
        logic [F_W-1:0]       tf;
        bit                   tlast;
        bit                   tgoal;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           req_type = REQ_HEUR;
    logic [NODE_W-1:0]    node_a = '0;
    logic [NODE_W-1:0]    node_b = '0;
    logic [15:0]          weight = '0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = CFG_START;
    logic [5:0]           cfg_data = '0;
    logic                 done;
    logic [NODE_W-1:0]    node_id;
    logic [F_W-1:0]       f_value;
    logic                 last;
    logic                 reached_goal;

    // mirror of the block's graph and registers
    logic [15:0]          heur_mem [MAX_NODES];
    logic [2*NODE_W-1:0]  edge_pair [MAX_EDGES];
    logic [15:0]          edge_cost [MAX_EDGES];
    int                   edge_cnt = 0;
    logic [4:0]           src_node = '0;
    logic [4:0]           dst_node = '0;
    logic [5:0]           used_nodes = 6'd32;

    closed_beat_t         run_beats [$];    // beats of the latest predicted search
    closed_beat_t         pending_beats [$];
    int                   errors = 0;
    bit                   gaps_on = 1'b1;
    dir_row_t             dir_tab [$];

    always #10 clk = ~clk;

    a_star_shortest_path_search u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .node_a       (node_a),
        .node_b       (node_b),
        .weight       (weight),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .node_id      (node_id),
        .f_value      (f_value),
        .last         (last),
        .reached_goal (reached_goal)
    );

    function automatic void add_row(input dir_row_t r);
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    function automatic logic [F_W-1:0] cost_sum(input logic [F_W-1:0] x,
                                                input logic [F_W-1:0] y);
        logic [F_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s > {1'b0, F_MAX} ? F_MAX : s[F_W-1:0];
    endfunction

    // best-first search over the mirrored graph, beats go to run_beats
    function automatic void search_graph();
        int             n;
        int             best;
        int             ea;
        int             eb;
        int             nb;
        bit             any;
        bit             open_q [MAX_NODES];
        bit             shut_q [MAX_NODES];
        logic [F_W-1:0] g_q [MAX_NODES];
        logic [F_W-1:0] best_f;
        logic [F_W-1:0] f;
        logic [F_W-1:0] g;
        closed_beat_t   bt;
        run_beats.delete();
        n = used_nodes > MAX_NODES ? MAX_NODES : int'(used_nodes);
        for (int i = 0; i < MAX_NODES; i++)
        begin
            open_q[i] = 1'b0;
            shut_q[i] = 1'b0;
            g_q[i] = '0;
        end
        if (src_node >= n)
            return;
        open_q[src_node] = 1'b1;
        forever
        begin
            any = 1'b0;
            best = 0;
            best_f = '0;
            for (int i = 0; i < n; i++)
            begin
                if (open_q[i])
                begin
                    f = cost_sum(g_q[i], {5'd0, heur_mem[i]});
                    if (!any || f < best_f)
                    begin
                        any = 1'b1;
                        best = i;
                        best_f = f;
                    end
                end
            end
            if (!any)
            begin
                // open set ran dry: mark the last beat, goal never reached
                if (run_beats.size() > 0)
                    run_beats[run_beats.size()-1].last = 1'b1;
                return;
            end
            open_q[best] = 1'b0;
            shut_q[best] = 1'b1;
            bt.node = best[NODE_W-1:0];
            bt.f = best_f;
            bt.last = 1'b0;
            bt.goal = 1'b0;
            if (best == dst_node)
            begin
                bt.last = 1'b1;
                bt.goal = 1'b1;
                run_beats.insert(run_beats.size(), bt);
                return;
            end
            if (run_beats.size() + 1 >= MAX_RESULTS)
            begin
                bt.last = 1'b1;
                run_beats.insert(run_beats.size(), bt);
                return;
            end
            run_beats.insert(run_beats.size(), bt);
            // relax every neighbour over stored edges; parallel edges keep the cheapest
            for (int e = 0; e < edge_cnt; e++)
            begin
                ea = edge_pair[e][4:0];
                eb = edge_pair[e][9:5];
                if (ea >= n || eb >= n)
                    continue;
                if (ea == best)
                    nb = eb;
                else if (eb == best)
                    nb = ea;
                else
                    continue;
                if (shut_q[nb])
                    continue;
                g = cost_sum(g_q[best], {5'd0, edge_cost[e]});
                if (!open_q[nb] || g < g_q[nb])
                begin
                    open_q[nb] = 1'b1;
                    g_q[nb] = g;
                end
            end
        end
    endfunction

    // apply one accepted command to the mirror
    function automatic void apply_cmd(input req_t r, input logic [4:0] a,
                                      input logic [4:0] b, input logic [15:0] w);
        run_beats.delete();
        case (r)
            REQ_HEUR: heur_mem[a] = w;
            REQ_EDGE:
            begin
                // full edge store drops the append
                if (edge_cnt < MAX_EDGES)
                begin
                    edge_pair[edge_cnt] = {b, a};
                    edge_cost[edge_cnt] = w;
                    edge_cnt++;
                end
            end
            REQ_RUN: search_graph();
            default: edge_cnt = 0;
        endcase
    endfunction

    // hand one command beat to the block, with a random hold-off before it when gaps_on is set
    task automatic send_cmd(input req_t r, input logic [4:0] a, input logic [4:0] b,
                            input logic [15:0] w, output bit taken_run);
        int gap;
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type = r;
        node_a = a;
        node_b = b;
        weight = w;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        taken_run = (r == REQ_RUN);
    endtask

    task automatic send_checked(input req_t r, input logic [4:0] a,
                                input logic [4:0] b, input logic [15:0] w);
        bit t;
        send_cmd(r, a, b, w, t);
        apply_cmd(r, a, b, w);
        foreach (run_beats[i])
            pending_beats.insert(pending_beats.size(), run_beats[i]);
    endtask

    // register write: only once the block has gone quiet
    task automatic write_reg(input cfg_idx_t idx, input logic [5:0] data);
        @(negedge clk);
        start = 1'b0;
        wait (pending_beats.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_START: src_node = data[4:0];
            CFG_GOAL:  dst_node = data[4:0];
            default:   used_nodes = data;
        endcase
    endtask

    function automatic logic [5:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd32;
            3:       return 6'($urandom_range(33, 63));
            4, 5:    return 6'($urandom_range(2, 32));
            default: return 6'($urandom_range(2, 10));
        endcase
    endfunction

    // result checker and watchdog
    int          stall_cycles = 0;
    closed_beat_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("a_star_shortest_path_search: mismatch");
                $finish;
            end
            if (done)
            begin
                if (pending_beats.size() == 0)
                begin
                    errors++;
                    if (errors <= NO_REPORT)
                        $display("unexpected beat node %0d f %0d last %0b goal %0b",
                                 node_id, f_value, last, reached_goal);
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (node_id !== want.node || f_value !== want.f ||
                        last !== want.last || reached_goal !== want.goal)
                    begin
                        errors++;
                        if (errors <= NO_REPORT)
                            $display("beat differs: want %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                     want.node, want.f, want.last, want.goal,
                                     node_id, f_value, last, reached_goal);
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int          items;
        int          batch;
        int          phase;
        int          pick;
        bit          t;
        closed_beat_t tb;
        logic [4:0]  ra;
        logic [4:0]  rb;
        req_t        rr;

        // directed table
        // heuristic extremes, lone start that is the goal
        add_row('{0, CFG_START, 0, REQ_HEUR, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_HEUR, 31, 31, 16'h0000, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_RUN, 0, 0, 0, 1, 1, 0, 21'd65535, 1, 1});
        // goal elsewhere, no edges: open set empties after the start
        add_row('{1, CFG_GOAL, 6'd1, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_CLEAR, 7, 9, 16'h1234, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_RUN, 0, 0, 0, 1, 1, 0, 21'd65535, 1, 0});
        // parallel edges, self loop, edge to the top node
        add_row('{0, CFG_START, 0, REQ_EDGE, 0, 1, 16'hFFFF, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_EDGE, 1, 0, 16'd5, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_EDGE, 2, 2, 16'd1, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_EDGE, 31, 0, 16'd0, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_EDGE, 31, 1, 16'h8000, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_HEUR, 1, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        // no nodes at all
        add_row('{1, CFG_COUNT, 6'd0, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_RUN, 0, 0, 0, 1, 0, 0, 0, 0, 0});
        // count above the maximum saturates, goal index upper bit dropped
        add_row('{1, CFG_COUNT, 6'd63, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{1, CFG_GOAL, 6'h3F, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{1, CFG_START, 6'd31, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        // start beyond the node count
        add_row('{1, CFG_COUNT, 6'd1, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{1, CFG_START, 6'd1, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_RUN, 0, 0, 0, 1, 0, 0, 0, 0, 0});
        // two nodes, start is the goal
        add_row('{1, CFG_COUNT, 6'd2, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{1, CFG_GOAL, 6'd1, REQ_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{0, CFG_START, 0, REQ_RUN, 0, 0, 0, 1, 1, 1, 21'd65535, 1, 1});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every heuristic gets a value before any search reads one
        for (int i = 0; i < MAX_NODES; i++)
            send_checked(REQ_HEUR, 5'(i), 5'($urandom), 16'($urandom));

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            else if (!dir_tab[i].typed)
                send_checked(dir_tab[i].req, dir_tab[i].a, dir_tab[i].b, dir_tab[i].w);
            else
            begin
                send_cmd(dir_tab[i].req, dir_tab[i].a, dir_tab[i].b, dir_tab[i].w, t);
                apply_cmd(dir_tab[i].req, dir_tab[i].a, dir_tab[i].b, dir_tab[i].w);
                if (dir_tab[i].tn > 0)
                begin
                    tb.node = dir_tab[i].tnode;
                    tb.f = dir_tab[i].tf;
                    tb.last = dir_tab[i].tlast;
                    tb.goal = dir_tab[i].tgoal;
                    pending_beats.insert(pending_beats.size(), tb);
                end
            end
        end

        // random phases
        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS)
        begin
            write_reg(CFG_START, 6'($urandom));
            write_reg(CFG_GOAL, 6'($urandom));
            write_reg(CFG_COUNT, pick_count());
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 3)
            begin
                // fill the edge store past its depth with a long chain and the
                // goal at its far end, so the run closes most of the graph
                write_reg(CFG_COUNT, 6'd32);
                write_reg(CFG_START, 6'd0);
                write_reg(CFG_GOAL, 6'd31);
                send_checked(REQ_CLEAR, 0, 0, 0);
                for (int i = 0; i < 136; i++)
                begin
                    if (i < 31)
                        send_checked(REQ_EDGE, 5'(i), 5'(i + 1), 16'($urandom_range(0, 300)));
                    else
                        send_checked(REQ_EDGE, 5'($urandom), 5'($urandom), 16'($urandom));
                end
                send_checked(REQ_RUN, 0, 0, 0);
                send_checked(REQ_CLEAR, 0, 0, 0);
                items += 139;
            end
            else
            begin
                batch = $urandom_range(8, 24);
                for (int k = 0; k < batch; k++)
                begin
                    pick = $urandom_range(0, 99);
                    ra = 5'($urandom);
                    rb = 5'($urandom);
                    if (used_nodes > 1 && used_nodes <= 32 && pick < 70)
                    begin
                        // keep most edges inside the graph in use
                        ra = 5'($urandom_range(0, used_nodes - 1));
                        rb = 5'($urandom_range(0, used_nodes - 1));
                    end
                    if (pick < 25)
                        rr = REQ_HEUR;
                    else if (pick < 75)
                        rr = REQ_EDGE;
                    else if (pick < 94)
                        rr = REQ_RUN;
                    else
                        rr = REQ_CLEAR;
                    send_checked(rr, ra, rb,
                                 ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 255)));
                    items++;
                    // now and then the sender holds off until the block has emptied out
                    if ($urandom_range(0, 15) == 0)
                    begin
                        @(negedge clk);
                        start = 1'b0;
                        wait (pending_beats.size() == 0);
                    end
                end
            end
            phase++;
        end

        @(negedge clk);
        start = 1'b0;
        wait (pending_beats.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("a_star_shortest_path_search: match");
        else
            $display("a_star_shortest_path_search: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
